/* src/itda_pkg.sv */
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants for the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned MagW    = 32;
  localparam int unsigned NumDig  = 10;
  localparam int unsigned CharW   = 7;
  localparam int unsigned DigW    = 4;
  localparam int unsigned CntW    = 4;
  localparam logic [CharW-1:0] ChZero  = 7'd48;
  localparam logic [CharW-1:0] ChMinus = 7'd45;

  typedef logic [NumDig-1:0][DigW-1:0] digits_t;

  typedef struct packed {
    logic    neg;
    digits_t dig;
    logic [CntW-1:0] nd;
  } conv_t;

endpackage

/* src/itda_dig_stage.sv */
// ----------------------------------------------------------------------------
// itda_dig_stage
// One pipeline stage: peel off one decimal digit of the remaining magnitude.
// ----------------------------------------------------------------------------
module itda_dig_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [itda_pkg::MagW-1:0] mag_i,
  input  itda_pkg::conv_t           conv_i,
  input  logic [itda_pkg::CntW-1:0] pos_i,
  output logic                      valid_o,
  output logic [itda_pkg::MagW-1:0] mag_o,
  output itda_pkg::conv_t           conv_o
);

  logic [63:0]               prod;
  logic [itda_pkg::MagW-1:0] quo;
  logic [itda_pkg::MagW+3:0] q10;
  logic [itda_pkg::DigW-1:0] rem;
  itda_pkg::conv_t           conv_d;
  logic                      valid_q;
  logic [itda_pkg::MagW-1:0] mag_q;
  itda_pkg::conv_t           conv_q;

  assign prod = {32'd0, mag_i} * 64'hCCCC_CCCD;
  assign quo  = {3'd0, prod[63:35]};
  assign q10  = {1'b0, quo, 3'd0} + {3'd0, quo, 1'b0};
  assign rem  = itda_pkg::DigW'({4'd0, mag_i} - q10);

  always_comb begin
    conv_d = conv_i;
    conv_d.dig[pos_i] = rem;
    if (rem != '0 || mag_i != '0) begin
      if (mag_i != '0) begin
        conv_d.nd = pos_i + itda_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= quo;
      conv_q <= conv_d;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign conv_o  = conv_q;

endmodule

/* src/itda_emit.sv */
// ----------------------------------------------------------------------------
// itda_emit
// Holds one converted number; sends one char per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module itda_emit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  itda_pkg::conv_t            conv_i,
  output logic                       ready_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [itda_pkg::CharW-1:0] char_o,
  output logic                       last_o
);

  logic                      busy_q, busy_d;
  logic                      sign_q, sign_d;
  logic [itda_pkg::CntW-1:0] idx_q, idx_d;
  itda_pkg::digits_t         dig_q, dig_d;
  logic [itda_pkg::CntW-1:0] cur;
  logic                      done;

  assign cur     = idx_q - itda_pkg::CntW'(1);
  assign valid_o = busy_q;
  assign char_o  = sign_q ? itda_pkg::ChMinus
                          : itda_pkg::ChZero + itda_pkg::CharW'(dig_q[cur]);
  assign last_o  = !sign_q && (idx_q == itda_pkg::CntW'(1));
  assign done    = busy_q && ready_i && last_o;
  assign ready_o = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    dig_d  = dig_q;
    if (busy_q && ready_i) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else begin
        idx_d = cur;
        if (last_o) begin
          busy_d = 1'b0;
        end
      end
    end
    if (valid_i && ready_o) begin
      busy_d = 1'b1;
      sign_d = conv_i.neg;
      idx_d  = conv_i.nd;
      dig_d  = conv_i.dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

endmodule

/* src/int_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// The first character leaves the character buffer after all ten digit stages.
// Throughput: one character per cycle while m_axis_tready is high; an item
// has 1 to 11 characters, sent through the single character output port.
// Ten digit stages, one multiply by reciprocal each, then a character buffer.
// Reset: asynchronous, active low, clears all valid and control state.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // char_code[6:0], zero pad
  output logic        m_axis_tlast    // is_last
);

  localparam int unsigned N = itda_pkg::NumDig;

  logic                      en;
  logic                      emit_ready;
  logic [N:0]                vld;
  logic [N:0][31:0]          mag;
  itda_pkg::conv_t [N:0]     conv;
  logic [6:0]                ch;

  assign en            = !vld[N] || emit_ready;
  assign s_axis_tready = en;
  assign vld[0]        = s_axis_tvalid;
  assign mag[0]        = s_axis_tdata[31] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
  always_comb begin
    conv[0]     = '0;
    conv[0].neg = s_axis_tdata[31];
    conv[0].nd  = itda_pkg::CntW'(1);
  end

  for (genvar g = 0; g < N; g++) begin : g_dig
    itda_dig_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .mag_i   (mag[g]),
      .conv_i  (conv[g]),
      .pos_i   (itda_pkg::CntW'(g)),
      .valid_o (vld[g+1]),
      .mag_o   (mag[g+1]),
      .conv_o  (conv[g+1])
    );
  end

  itda_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[N]),
    .conv_i  (conv[N]),
    .ready_o (emit_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .char_o  (ch),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, ch};

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ch == itda_pkg::ChMinus ||
                       (ch >= itda_pkg::ChZero && ch <= 7'd57)))
    else $error("bad character code");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ch == itda_pkg::ChMinus) |-> !m_axis_tlast)
    else $error("minus marked last");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld[N] && !emit_ready) |=> $stable(conv[N]))
    else $error("pipeline moved while stalled");

endmodule
